@@ rtl/mwc_pkg.sv @@
// mwc_pkg: shared types, constants and codes of the multi-weight combiner.
// Used by every file in rtl/; depends on nothing.

package mwc_pkg;

  // Field widths
  localparam int VAL_W      = 16;  // signed Q8.8 evaluator value / weight
  localparam int TERM_W     = 24;  // floor(value * weight / 256) always fits
  localparam int DATA_W     = 32;  // signed Q24.8 result
  localparam int NUM_VALS   = 4;   // value fields per slot
  localparam int S_DATA_W   = NUM_VALS * VAL_W;

  // Evaluator limit: smaller of the evaluator count and the value fields
  localparam int MAX_EVALS  = 4;
  localparam int EVAL_LIM   = (MAX_EVALS < NUM_VALS) ? MAX_EVALS : NUM_VALS;
  localparam int IDX_W      = (EVAL_LIM > 1) ? $clog2(EVAL_LIM) : 1;

  // Slot grouping
  localparam int MAX_SLOTS_DEF = 16;

  // Configuration registers
  localparam int MODE_W     = 3;
  localparam int SPC_W      = 5;
  localparam int NACT_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [SPC_W-1:0]  SPC_RST  = SPC_W'(7);
  localparam logic [NACT_W-1:0] NACT_RST = NACT_W'(1);

  // Q8.8 one, start value of the product
  localparam logic signed [DATA_W-1:0] ONE_Q8 = DATA_W'(256);

  // Queue between front and back
  localparam int QDEPTH     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE = 3'd0,
    CFG_SPC  = 3'd1,
    CFG_NACT = 3'd2,
    CFG_WA   = 3'd3,
    CFG_WB   = 3'd4,
    CFG_WC   = 3'd5,
    CFG_WD   = 3'd6
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD     = 3'd0,
    MODE_ADD_BLK = 3'd1,
    MODE_MUL     = 3'd2,
    MODE_MAX     = 3'd3,
    MODE_MAX_BLK = 3'd4,
    MODE_MIN     = 3'd5
  } mode_e;

  // Merge operation decided by the front
  typedef enum logic [2:0] {
    OP_SUM  = 3'd0,
    OP_MUL  = 3'd1,
    OP_MAX  = 3'd2,
    OP_MIN  = 3'd3,
    OP_ZERO = 3'd4
  } op_e;

  typedef logic signed [TERM_W-1:0] term_t;

  typedef struct packed {
    logic [MODE_W-1:0]                  mode;
    logic [SPC_W-1:0]                   spc;
    logic [NACT_W-1:0]                  nact;
    logic [NUM_VALS-1:0][VAL_W-1:0]     weights;
  } cfg_t;

  // One classified slot as it waits in the queue
  typedef struct packed {
    op_e                                op;
    logic                               zero_slot;  // blocked slot, value forced to 0
    logic                               cumulate;   // output the running cell sum
    logic                               first;      // first slot of a cell
    logic                               last;       // last slot of a cell
    logic [IDX_W-1:0]                   last_idx;   // active evaluators minus one
    logic [NUM_VALS-1:0][TERM_W-1:0]    terms;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ rtl/mwc_front.sv @@
// mwc_front: accepts slots, scales the values by their weights, counts slots
// within a cell and classifies the merge. Depends on mwc_pkg.

module mwc_front #(
  parameter int MAX_SLOTS = mwc_pkg::MAX_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mwc_pkg::cfg_t                  cfg_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [mwc_pkg::S_DATA_W-1:0]   s_axis_tdata_i,
  input  mwc_pkg::q_status_t             q_status_i,
  output logic                           push_o,
  output mwc_pkg::entry_t                entry_o
);

  localparam int PosW = $clog2(MAX_SLOTS);
  localparam int CmpW = (PosW + 1 > mwc_pkg::SPC_W) ? PosW + 1 : mwc_pkg::SPC_W;

  logic                                  accept;
  logic [PosW-1:0]                       pos_q, pos_d;
  logic [CmpW-1:0]                       spc_eff;
  logic [CmpW-1:0]                       pos_inc;
  logic                                  last;
  logic [mwc_pkg::NACT_W-1:0]            nact;
  logic                                  allowed;
  logic                                  blocked_mode;
  logic signed [mwc_pkg::VAL_W-1:0]      vals [mwc_pkg::NUM_VALS];
  logic signed [2*mwc_pkg::VAL_W-1:0]    prods [mwc_pkg::NUM_VALS];
  mwc_pkg::term_t                        terms [mwc_pkg::NUM_VALS];

  // Handshake: take a transfer whenever the queue has room
  assign s_axis_tready_o = !q_status_i.full;
  assign accept          = s_axis_tvalid_i && !q_status_i.full;
  assign push_o          = accept;

  // Clamp the configured counts into their legal ranges
  always_comb begin
    if (cfg_i.spc == '0) begin
      spc_eff = CmpW'(1);
    end else if (CmpW'(cfg_i.spc) > CmpW'(MAX_SLOTS)) begin
      spc_eff = CmpW'(MAX_SLOTS);
    end else begin
      spc_eff = CmpW'(cfg_i.spc);
    end
    if (cfg_i.nact == '0) begin
      nact = mwc_pkg::NACT_W'(1);
    end else if (cfg_i.nact > mwc_pkg::NACT_W'(mwc_pkg::EVAL_LIM)) begin
      nact = mwc_pkg::NACT_W'(mwc_pkg::EVAL_LIM);
    end else begin
      nact = cfg_i.nact;
    end
  end

  // Scale each value: floor(v * w / 256)
  always_comb begin
    for (int i = 0; i < mwc_pkg::NUM_VALS; i++) begin
      vals[i]  = $signed(s_axis_tdata_i[i*mwc_pkg::VAL_W +: mwc_pkg::VAL_W]);
      prods[i] = vals[i] * $signed(cfg_i.weights[i]);
      terms[i] = mwc_pkg::term_t'(prods[i][2*mwc_pkg::VAL_W-1:8]);
    end
  end

  // Slot is allowed only if every active value is strictly positive
  always_comb begin
    allowed = 1'b1;
    for (int i = 0; i < mwc_pkg::NUM_VALS; i++) begin
      if ((mwc_pkg::NACT_W'(i) < nact) && (vals[i] <= 0)) begin
        allowed = 1'b0;
      end
    end
  end

  // Classify the merge and build the queue entry
  always_comb begin
    entry_o.cumulate = 1'b0;
    blocked_mode     = 1'b0;
    unique case (mwc_pkg::mode_e'(cfg_i.mode))
      mwc_pkg::MODE_ADD: begin
        entry_o.op = mwc_pkg::OP_SUM;
      end
      mwc_pkg::MODE_ADD_BLK: begin
        entry_o.op       = mwc_pkg::OP_SUM;
        entry_o.cumulate = 1'b1;
        blocked_mode     = 1'b1;
      end
      mwc_pkg::MODE_MUL: begin
        entry_o.op       = mwc_pkg::OP_MUL;
        entry_o.cumulate = 1'b1;
      end
      mwc_pkg::MODE_MAX: begin
        entry_o.op = mwc_pkg::OP_MAX;
      end
      mwc_pkg::MODE_MAX_BLK: begin
        entry_o.op       = mwc_pkg::OP_MAX;
        entry_o.cumulate = 1'b1;
        blocked_mode     = 1'b1;
      end
      mwc_pkg::MODE_MIN: begin
        entry_o.op       = mwc_pkg::OP_MIN;
        entry_o.cumulate = 1'b1;
      end
      default: begin
        entry_o.op = mwc_pkg::OP_ZERO;
      end
    endcase
    entry_o.zero_slot = blocked_mode && !allowed;
    entry_o.last_idx  = mwc_pkg::IDX_W'(nact - mwc_pkg::NACT_W'(1));
    entry_o.first     = (pos_q == '0);
    entry_o.last      = last;

    // Inactive terms: zero for the sum, a copy of term 0 for max and min
    for (int i = 0; i < mwc_pkg::NUM_VALS; i++) begin
      if (mwc_pkg::NACT_W'(i) < nact) begin
        entry_o.terms[i] = terms[i];
      end else if (entry_o.op == mwc_pkg::OP_MAX || entry_o.op == mwc_pkg::OP_MIN) begin
        entry_o.terms[i] = terms[0];
      end else begin
        entry_o.terms[i] = '0;
      end
    end
  end

  // Slot position within the cell
  assign pos_inc = CmpW'(pos_q) + CmpW'(1);
  assign last    = (pos_inc >= spc_eff);

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      pos_d = last ? '0 : pos_inc[PosW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

@@ rtl/mwc_queue.sv @@
// mwc_queue: short FIFO of classified slots between front and back.
// Depends on mwc_pkg.

module mwc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mwc_pkg::entry_t    entry_i,
  input  logic               pop_i,
  output mwc_pkg::entry_t    head_o,
  output mwc_pkg::q_status_t status_o
);

  localparam int PtrW = $clog2(mwc_pkg::QDEPTH);
  localparam int CntW = $clog2(mwc_pkg::QDEPTH + 1);

  mwc_pkg::entry_t  mem [mwc_pkg::QDEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign status_o = '{full:  (count_q == CntW'(mwc_pkg::QDEPTH)),
                      empty: (count_q == '0)};
  assign head_o   = mem[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(mwc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(mwc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    priority if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ rtl/mwc_back.sv @@
// mwc_back: merges the terms of the queue head, iterates the product, keeps
// the running cell sum and holds the output register. Depends on mwc_pkg.

module mwc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mwc_pkg::entry_t               head_i,
  input  mwc_pkg::q_status_t            q_status_i,
  output logic                          pop_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [mwc_pkg::DATA_W-1:0]    m_axis_tdata_o,
  output logic                          m_axis_tlast_o
);

  localparam int DW   = mwc_pkg::DATA_W;
  localparam int TW   = mwc_pkg::TERM_W;
  localparam int MulW = DW + TW;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_ACC  = 3'b100
  } state_e;

  state_e                       state_q, state_d;
  logic [mwc_pkg::IDX_W-1:0]    idx_q, idx_d;
  logic signed [DW-1:0]         slot_q, slot_d;
  logic signed [DW-1:0]         cell_sum_q, cell_sum_d;
  logic                         out_valid_q, out_valid_d;
  logic [DW-1:0]                out_data_q, out_data_d;
  logic                         out_last_q, out_last_d;

  logic signed [TW-1:0]         t [mwc_pkg::NUM_VALS];
  logic signed [TW+1:0]         sum_all;
  logic signed [TW-1:0]         max01, max23, max_all;
  logic signed [TW-1:0]         min01, min23, min_all;
  logic signed [DW-1:0]         merged;
  logic signed [TW-1:0]         mul_term;
  logic signed [MulW-1:0]       mul_prod;
  logic signed [MulW-1:0]       mul_shr;
  logic signed [DW-1:0]         mul_sat;
  logic signed [DW:0]           acc_wide;
  logic signed [DW-1:0]         acc_sat;
  logic signed [DW-1:0]         new_sum;
  logic                         out_free;

  // Combinational merges over the four terms (inactive ones already neutral)
  always_comb begin
    for (int i = 0; i < mwc_pkg::NUM_VALS; i++) begin
      t[i] = $signed(head_i.terms[i]);
    end
    sum_all = ((TW+2)'(t[0]) + (TW+2)'(t[1])) + ((TW+2)'(t[2]) + (TW+2)'(t[3]));
    max01   = (t[1] > t[0]) ? t[1] : t[0];
    max23   = (t[3] > t[2]) ? t[3] : t[2];
    max_all = (max23 > max01) ? max23 : max01;
    min01   = (t[1] < t[0]) ? t[1] : t[0];
    min23   = (t[3] < t[2]) ? t[3] : t[2];
    min_all = (min23 < min01) ? min23 : min01;
    unique case (head_i.op)
      mwc_pkg::OP_SUM: merged = DW'(sum_all);
      mwc_pkg::OP_MAX: merged = DW'(max_all);
      mwc_pkg::OP_MIN: merged = DW'(min_all);
      default:         merged = '0;
    endcase
    if (head_i.zero_slot) begin
      merged = '0;
    end
  end

  // One product step: sat32(floor(slot * term / 256))
  always_comb begin
    mul_term = $signed(head_i.terms[idx_q]);
    mul_prod = slot_q * mul_term;
    mul_shr  = mul_prod >>> 8;
    if ((mul_shr[MulW-1:DW-1] == '0) || (mul_shr[MulW-1:DW-1] == '1)) begin
      mul_sat = mul_shr[DW-1:0];
    end else begin
      mul_sat = mul_shr[MulW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
  end

  // Running cell sum with saturation
  always_comb begin
    acc_wide = (DW+1)'(cell_sum_q) + (DW+1)'(slot_q);
    if (acc_wide[DW] != acc_wide[DW-1]) begin
      acc_sat = acc_wide[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      acc_sat = acc_wide[DW-1:0];
    end
    new_sum = head_i.first ? slot_q : acc_sat;
  end

  assign out_free = !out_valid_q || m_axis_tready_i;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    slot_d      = slot_q;
    cell_sum_d  = cell_sum_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    pop_o       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          if (head_i.op == mwc_pkg::OP_MUL) begin
            slot_d  = mwc_pkg::ONE_Q8;
            idx_d   = '0;
            state_d = ST_MUL;
          end else begin
            slot_d  = merged;
            state_d = ST_ACC;
          end
        end
      end
      ST_MUL: begin
        slot_d = mul_sat;
        if (idx_q == head_i.last_idx) begin
          state_d = ST_ACC;
        end else begin
          idx_d = idx_q + mwc_pkg::IDX_W'(1);
        end
      end
      ST_ACC: begin
        if (out_free) begin
          cell_sum_d  = new_sum;
          out_valid_d = 1'b1;
          out_data_d  = head_i.cumulate ? new_sum : slot_q;
          out_last_d  = head_i.last;
          pop_o       = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cell_sum_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cell_sum_q  <= cell_sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

@@ rtl/multi_weight_combiner.sv @@
// multi_weight_combiner: top level with the configuration registers, the
// front, the slot queue and the back. Depends on mwc_pkg, mwc_front,
// mwc_queue and mwc_back.
//
// Channel   Dir  Signals                                   Contents
// s_axis    in   tvalid/tready/tdata[63:0]                 value_a..value_d
// m_axis    out  tvalid/tready/tdata[31:0]/tlast           combined, cell_last
// cfg       in   cfg_we_i/cfg_idx_i[2:0]/cfg_wdata_i[15:0] register writes
//
// The front takes a slot every cycle while the 4-entry queue has room.
// The back handles one slot at a time: IDLE, ACC in sum, max, min and unknown
// modes; IDLE, MUL per active evaluator, ACC in multiply mode (one 32x24 product per cycle).
// A stalled output register holds the back; the queue keeps the front moving.
// Reset clears the slot counter, the cell sum and all valid flags.

module multi_weight_combiner #(
  parameter int MAX_SLOTS = mwc_pkg::MAX_SLOTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // value_a [15:0], value_b [31:16], value_c [47:32], value_d [63:48]
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [mwc_pkg::S_DATA_W-1:0]     s_axis_tdata_i,
  // combined [31:0]; cell_last travels as tlast
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [mwc_pkg::DATA_W-1:0]       m_axis_tdata_o,
  output logic                             m_axis_tlast_o,
  input  logic                             cfg_we_i,
  input  logic [mwc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mwc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  logic [mwc_pkg::MODE_W-1:0]                          mode_q;
  logic [mwc_pkg::SPC_W-1:0]                           spc_q;
  logic [mwc_pkg::NACT_W-1:0]                          nact_q;
  logic [mwc_pkg::NUM_VALS-1:0][mwc_pkg::VAL_W-1:0]    weights_q;

  mwc_pkg::cfg_t       cfg;
  mwc_pkg::entry_t     push_entry;
  mwc_pkg::entry_t     head_entry;
  mwc_pkg::q_status_t  q_status;
  logic                push;
  logic                pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= '0;
      spc_q     <= mwc_pkg::SPC_RST;
      nact_q    <= mwc_pkg::NACT_RST;
      weights_q <= '0;
    end else if (cfg_we_i) begin
      unique case (mwc_pkg::cfg_idx_e'(cfg_idx_i))
        mwc_pkg::CFG_MODE: mode_q       <= cfg_wdata_i[mwc_pkg::MODE_W-1:0];
        mwc_pkg::CFG_SPC:  spc_q        <= cfg_wdata_i[mwc_pkg::SPC_W-1:0];
        mwc_pkg::CFG_NACT: nact_q       <= cfg_wdata_i[mwc_pkg::NACT_W-1:0];
        mwc_pkg::CFG_WA:   weights_q[0] <= cfg_wdata_i;
        mwc_pkg::CFG_WB:   weights_q[1] <= cfg_wdata_i;
        mwc_pkg::CFG_WC:   weights_q[2] <= cfg_wdata_i;
        mwc_pkg::CFG_WD:   weights_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg = '{mode: mode_q, spc: spc_q, nact: nact_q, weights: weights_q};

  mwc_front #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_i           (cfg),
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .q_status_i      (q_status),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  mwc_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .head_o   (head_entry),
    .status_o (q_status)
  );

  mwc_back u_back (
    .clk_i,
    .rst_ni,
    .head_i          (head_entry),
    .q_status_i      (q_status),
    .pop_o           (pop),
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tlast_o
  );

  // No push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_status.full)
    else $error("slot pushed into a full queue");

  // No pop from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_status.empty)
    else $error("slot popped from an empty queue");

  // Every finished slot shows up in the output register next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |=> m_axis_tvalid_o)
    else $error("finished slot not presented on the output");

endmodule
